### rtl/cpt_pkg.sv
// shared types and constants of the call profile table
package cpt_pkg;

   localparam int unsigned MAX_ITEMS = 32;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 32;

   // operation codes
   localparam logic [2:0] OP_CLEAR    = 3'd0;
   localparam logic [2:0] OP_REGISTER = 3'd1;
   localparam logic [2:0] OP_RECORD   = 3'd2;
   localparam logic [2:0] OP_QUERY    = 3'd3;
   localparam logic [2:0] OP_MARK     = 3'd4;
   localparam logic [2:0] OP_RANK     = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_BAD_IDX  = 2'd2;
   localparam logic [1:0] ST_NO_RANK  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROMOTE_EN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH0    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH1    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH2    = 2'd3;

   localparam logic [31:0] THRESH0_RESET = 32'd100;
   localparam logic [31:0] THRESH1_RESET = 32'd1000;
   localparam logic [31:0] THRESH2_RESET = 32'd10000;

   typedef struct packed {
      logic [2:0]  operation;
      logic [5:0]  entry_index;
      logic [63:0] call_cost;
      logic [1:0]  new_tier;
      logic [6:0]  rank_limit;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  result_index;
      logic [63:0] entry_calls;
      logic [63:0] cycle_sum;
      logic [63:0] cycle_min;
      logic [63:0] cycle_max;
      logic [1:0]  tier;
      logic        promote_flag;
      logic        hot_flag;
      logic [63:0] global_calls;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [63:0] count;
      logic [63:0] sum;
      logic [63:0] min;
      logic [63:0] max;
      logic [1:0]  tier;
      logic        promote;
      logic        hot;
   } entry_type;

   typedef struct packed {
      logic        promote_en;
      logic [31:0] thresh0;
      logic [31:0] thresh1;
      logic [31:0] thresh2;
   } cfg_type;

endpackage

### rtl/cpt_update.sv
// record update of one table entry: count, sum, min, max and promote trigger
module cpt_update (
   input  cpt_pkg::entry_type cur,
   input  logic [63:0]        cost,
   input  cpt_pkg::cfg_type   cfg,
   output cpt_pkg::entry_type nxt
);

   logic [63:0] cnt_new;
   logic        hit;

   // statistics
   always_comb begin
      cnt_new = cur.count + 64'd1;
      nxt = cur;
      nxt.count = cnt_new;
      nxt.sum = cur.sum + cost;
      if (cost < cur.min) begin
         nxt.min = cost;
      end
      if (cost > cur.max) begin
         nxt.max = cost;
      end
      nxt.promote = cur.promote | (cfg.promote_en & hit);
   end

   // tier threshold check
   always_comb begin
      case (cur.tier)
         2'd0: hit = cnt_new >= {32'd0, cfg.thresh0};
         2'd1: hit = cnt_new >= {32'd0, cfg.thresh1};
         2'd2: hit = cnt_new >= {32'd0, cfg.thresh2};
         default: hit = 1'b0;
      endcase
   end

endmodule

### rtl/call_profile_table_with_tier_trigger.sv
// top level of the call profile table with tier trigger
//
// Channels: req_valid/req_stall/req_data carries one command word in,
// rsp_valid/rsp_stall/rsp_data carries result words out; a word moves on a
// rising edge with valid high and stall low. csr_valid/csr_ready writes the
// promote enable and the three tier thresholds (csr_ready is always high).
// Commands run one at a time; req_stall is high while a command is in work.
// Clear, register and error results come from the response state; record,
// query and mark tier read the entry memory, then modify and write the entry.
// Rank hot walks the table once per emitted word, over the single read
// port of the entry memory and the one shared sum comparator.
// Reset clears the entry count, the call total and the registers to their
// defaults; the entry memory is not cleared, entries are written when
// allocated. A finished result sits in the output register while the
// receiver stalls; the next command is taken meanwhile, but its result
// waits until that register is free.
module call_profile_table_with_tier_trigger #(
   parameter int unsigned TABLE_ENTRIES = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  cpt_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output cpt_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cpt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cpt_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
   localparam int unsigned EU_W  = $clog2(TABLE_ENTRIES + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RESP = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_MOD  = 3'd3;
   localparam logic [2:0] S_SCAN = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   logic [2:0]              state_ff, state_in;
   cpt_pkg::req_type        cmd_ff, cmd_in;
   logic [1:0]              err_ff, err_in;
   logic [EU_W-1:0]         eu_ff, eu_in;
   logic [63:0]             calls_ff, calls_in;
   cpt_pkg::cfg_type        cfg_ff;
   logic [TABLE_ENTRIES-1:0] taken_ff, taken_in;
   logic [EU_W-1:0]         scan_ff, scan_in;
   logic                    pend_ff, pend_in;
   logic [IDX_W-1:0]        pidx_ff, pidx_in;
   logic                    have_ff, have_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   cpt_pkg::entry_type      best_ff, best_in;
   logic [6:0]              n_ff, n_in;
   logic [6:0]              k_ff, k_in;
   cpt_pkg::rsp_type        rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   cpt_pkg::entry_type      entry_mem [TABLE_ENTRIES];
   cpt_pkg::entry_type      rd_data_ff;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   cpt_pkg::entry_type      wr_data;

   cpt_pkg::entry_type      rec_entry;
   cpt_pkg::entry_type      mod_entry;
   cpt_pkg::entry_type      new_entry;
   cpt_pkg::rsp_type        err_rsp;
   logic                    out_free;
   logic                    accept;
   logic                    idx_ok;
   logic [6:0]              eu7;
   logic [6:0]              n_calc;
   logic [63:0]             calls_rec;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.promote_en <= 1'b0;
         cfg_ff.thresh0    <= cpt_pkg::THRESH0_RESET;
         cfg_ff.thresh1    <= cpt_pkg::THRESH1_RESET;
         cfg_ff.thresh2    <= cpt_pkg::THRESH2_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            cpt_pkg::CSR_PROMOTE_EN: cfg_ff.promote_en <= csr_wdata[0];
            cpt_pkg::CSR_THRESH0:    cfg_ff.thresh0    <= csr_wdata;
            cpt_pkg::CSR_THRESH1:    cfg_ff.thresh1    <= csr_wdata;
            cpt_pkg::CSR_THRESH2:    cfg_ff.thresh2    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   cpt_update u_update (
      .cur  (rd_data_ff),
      .cost (cmd_ff.call_cost),
      .cfg  (cfg_ff),
      .nxt  (rec_entry)
   );

   // operand decode
   always_comb begin
      eu7    = 7'(eu_ff);
      idx_ok = {1'b0, req_data.entry_index} < eu7;
      n_calc = req_data.rank_limit;
      if (eu7 < n_calc) begin
         n_calc = eu7;
      end
      if (7'(cpt_pkg::MAX_ITEMS) < n_calc) begin
         n_calc = 7'(cpt_pkg::MAX_ITEMS);
      end
      calls_rec = calls_ff + 64'd1;

      new_entry         = '0;
      new_entry.min     = '1;

      mod_entry = rd_data_ff;
      case (cmd_ff.operation)
         cpt_pkg::OP_RECORD: mod_entry = rec_entry;
         cpt_pkg::OP_MARK: begin
            mod_entry.tier    = cmd_ff.new_tier;
            mod_entry.promote = 1'b0;
         end
         default: ;
      endcase

      err_rsp              = '0;
      err_rsp.status       = err_ff;
      err_rsp.global_calls = calls_ff;
      err_rsp.last         = 1'b1;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      err_in       = err_ff;
      eu_in        = eu_ff;
      calls_in     = calls_ff;
      taken_in     = taken_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      have_in      = have_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rd_en        = 1'b0;
      rd_addr      = cmd_ff.entry_index[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = cmd_ff.entry_index[IDX_W-1:0];
      wr_data      = mod_entry;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_data;
               err_in = cpt_pkg::ST_OK;
               case (req_data.operation)
                  cpt_pkg::OP_CLEAR: state_in = S_RESP;
                  cpt_pkg::OP_REGISTER: begin
                     state_in = S_RESP;
                     if (eu_ff >= EU_W'(TABLE_ENTRIES)) begin
                        err_in = cpt_pkg::ST_FULL;
                     end
                  end
                  cpt_pkg::OP_RECORD, cpt_pkg::OP_QUERY, cpt_pkg::OP_MARK: begin
                     if (idx_ok) begin
                        state_in = S_READ;
                     end else begin
                        state_in = S_RESP;
                        err_in   = cpt_pkg::ST_BAD_IDX;
                     end
                  end
                  cpt_pkg::OP_RANK: begin
                     n_in     = n_calc;
                     k_in     = '0;
                     scan_in  = '0;
                     pend_in  = 1'b0;
                     have_in  = 1'b0;
                     taken_in = '0;
                     if (n_calc == 7'd0) begin
                        state_in = S_RESP;
                        err_in   = cpt_pkg::ST_NO_RANK;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // single word results: clear, register and errors
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (err_ff != cpt_pkg::ST_OK) begin
                  rsp_in = err_rsp;
               end else if (cmd_ff.operation == cpt_pkg::OP_CLEAR) begin
                  rsp_in      = '0;
                  rsp_in.last = 1'b1;
                  eu_in       = '0;
                  calls_in    = '0;
               end else begin
                  wr_en                = 1'b1;
                  wr_addr              = eu_ff[IDX_W-1:0];
                  wr_data              = new_entry;
                  eu_in                = eu_ff + EU_W'(1);
                  rsp_in               = '0;
                  rsp_in.result_index  = 6'(eu_ff);
                  rsp_in.cycle_min     = '1;
                  rsp_in.global_calls  = calls_ff;
                  rsp_in.last          = 1'b1;
               end
            end
         end

         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_MOD;
         end

         // read-modify-write of one entry
         S_MOD: begin
            if (out_free) begin
               wr_en = 1'b1;
               if (cmd_ff.operation == cpt_pkg::OP_RECORD) begin
                  calls_in = calls_rec;
               end
               rsp_in.status       = cpt_pkg::ST_OK;
               rsp_in.result_index = cmd_ff.entry_index;
               rsp_in.entry_calls  = mod_entry.count;
               rsp_in.cycle_sum    = mod_entry.sum;
               rsp_in.cycle_min    = mod_entry.min;
               rsp_in.cycle_max    = mod_entry.max;
               rsp_in.tier         = mod_entry.tier;
               rsp_in.promote_flag = mod_entry.promote;
               rsp_in.hot_flag     = mod_entry.hot;
               rsp_in.global_calls = (cmd_ff.operation == cpt_pkg::OP_RECORD) ?
                                     calls_rec : calls_ff;
               rsp_in.last         = 1'b1;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end

         // walk the table for the largest untaken sum
         S_SCAN: begin
            if (scan_ff < eu_ff) begin
               rd_en   = 1'b1;
               rd_addr = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + EU_W'(1);
               pend_in = 1'b1;
               pidx_in = scan_ff[IDX_W-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && !taken_ff[pidx_ff] &&
                (!have_ff || (rd_data_ff.sum > best_ff.sum))) begin
               have_in     = 1'b1;
               best_idx_in = pidx_ff;
               best_in     = rd_data_ff;
            end
            if ((scan_ff >= eu_ff) && !pend_ff) begin
               state_in = S_EMIT;
            end
         end

         // emit the winner and mark it hot
         S_EMIT: begin
            if (out_free) begin
               wr_en                 = 1'b1;
               wr_addr               = best_idx_ff;
               wr_data               = best_ff;
               wr_data.hot           = 1'b1;
               taken_in[best_idx_ff] = 1'b1;
               rsp_in.status         = cpt_pkg::ST_OK;
               rsp_in.result_index   = 6'(best_idx_ff);
               rsp_in.entry_calls    = best_ff.count;
               rsp_in.cycle_sum      = best_ff.sum;
               rsp_in.cycle_min      = best_ff.min;
               rsp_in.cycle_max      = best_ff.max;
               rsp_in.tier           = best_ff.tier;
               rsp_in.promote_flag   = best_ff.promote;
               rsp_in.hot_flag       = 1'b1;
               rsp_in.global_calls   = calls_ff;
               rsp_in.last           = (k_ff + 7'd1) == n_ff;
               rsp_valid_in          = 1'b1;
               k_in                  = k_ff + 7'd1;
               scan_in               = '0;
               have_in               = 1'b0;
               state_in              = ((k_ff + 7'd1) == n_ff) ? S_IDLE : S_SCAN;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         eu_ff        <= '0;
         calls_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eu_ff        <= eu_in;
         calls_ff     <= calls_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      err_ff      <= err_in;
      taken_ff    <= taken_in;
      scan_ff     <= scan_in;
      pidx_ff     <= pidx_in;
      have_ff     <= have_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      rsp_ff      <= rsp_in;
   end

endmodule

### sim/call_profile_table_with_tier_trigger_tb.sv
// self-checking testbench of the call profile table with tier trigger
module call_profile_table_with_tier_trigger_tb;

   localparam int unsigned ENTRIES = 32;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   cpt_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   cpt_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [cpt_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [cpt_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow copy of the table and registers
   cpt_pkg::entry_type table_shadow [ENTRIES];
   int unsigned used_shadow;
   logic [63:0] total_shadow;
   cpt_pkg::cfg_type cfg_shadow;

   cpt_pkg::rsp_type expected_words [$];
   int unsigned mismatch_count = 0;
   int unsigned words_checked = 0;
   int unsigned words_sent = 0;
   bit idle_enable = 1'b1;

   call_profile_table_with_tier_trigger #(.TABLE_ENTRIES(ENTRIES)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h (word %0d)", what, got, want,
               words_checked);
      mismatch_count++;
   endtask

   function automatic cpt_pkg::rsp_type error_word(input logic [1:0] status);
      cpt_pkg::rsp_type w;
      w = '0;
      w.status = status;
      w.global_calls = total_shadow;
      w.last = 1'b1;
      return w;
   endfunction

   function automatic cpt_pkg::rsp_type entry_word(input int unsigned idx,
                                                   input bit is_last);
      cpt_pkg::rsp_type w;
      w.status = cpt_pkg::ST_OK;
      w.result_index = idx[5:0];
      w.entry_calls = table_shadow[idx].count;
      w.cycle_sum = table_shadow[idx].sum;
      w.cycle_min = table_shadow[idx].min;
      w.cycle_max = table_shadow[idx].max;
      w.tier = table_shadow[idx].tier;
      w.promote_flag = table_shadow[idx].promote;
      w.hot_flag = table_shadow[idx].hot;
      w.global_calls = total_shadow;
      w.last = is_last;
      return w;
   endfunction

   // work out the words one command causes and update the shadow table
   task automatic predict_command(input cpt_pkg::req_type c);
      int unsigned n, best;
      bit taken [ENTRIES];
      bit hit;
      cpt_pkg::entry_type e;
      for (int i = 0; i < ENTRIES; i++) taken[i] = 1'b0;
      case (c.operation)
         cpt_pkg::OP_CLEAR: begin
            used_shadow = 0;
            total_shadow = '0;
            expected_words.push_back(error_word(cpt_pkg::ST_OK));
         end
         cpt_pkg::OP_REGISTER: begin
            if (used_shadow >= ENTRIES) begin
               expected_words.push_back(error_word(cpt_pkg::ST_FULL));
            end else begin
               table_shadow[used_shadow] = '{count: '0, sum: '0, min: '1, max: '0,
                                             tier: 2'd0, promote: 1'b0, hot: 1'b0};
               used_shadow++;
               expected_words.push_back(entry_word(used_shadow - 1, 1'b1));
            end
         end
         cpt_pkg::OP_RECORD, cpt_pkg::OP_QUERY, cpt_pkg::OP_MARK: begin
            if (c.entry_index >= used_shadow) begin
               expected_words.push_back(error_word(cpt_pkg::ST_BAD_IDX));
            end else begin
               e = table_shadow[c.entry_index];
               if (c.operation == cpt_pkg::OP_RECORD) begin
                  e.count = e.count + 64'd1;
                  e.sum = e.sum + c.call_cost;
                  if (c.call_cost < e.min) e.min = c.call_cost;
                  if (c.call_cost > e.max) e.max = c.call_cost;
                  total_shadow = total_shadow + 64'd1;
                  if (cfg_shadow.promote_en && !e.promote) begin
                     hit = (e.tier == 2'd0 && e.count >= {32'd0, cfg_shadow.thresh0}) ||
                           (e.tier == 2'd1 && e.count >= {32'd0, cfg_shadow.thresh1}) ||
                           (e.tier == 2'd2 && e.count >= {32'd0, cfg_shadow.thresh2});
                     if (hit) e.promote = 1'b1;
                  end
               end else if (c.operation == cpt_pkg::OP_MARK) begin
                  e.tier = c.new_tier;
                  e.promote = 1'b0;
               end
               table_shadow[c.entry_index] = e;
               expected_words.push_back(entry_word(32'(c.entry_index), 1'b1));
            end
         end
         cpt_pkg::OP_RANK: begin
            n = used_shadow;
            if (c.rank_limit < n) n = 32'(c.rank_limit);
            if (n > cpt_pkg::MAX_ITEMS) n = cpt_pkg::MAX_ITEMS;
            if (n == 0) begin
               expected_words.push_back(error_word(cpt_pkg::ST_NO_RANK));
            end else begin
               for (int k = 0; k < n; k++) begin
                  best = ENTRIES;
                  for (int i = 0; i < used_shadow; i++) begin
                     if (!taken[i] && (best == ENTRIES ||
                                       table_shadow[i].sum > table_shadow[best].sum))
                        best = i;
                  end
                  taken[best] = 1'b1;
                  table_shadow[best].hot = 1'b1;
                  expected_words.push_back(entry_word(best, k + 1 == n));
               end
            end
         end
         default: ;
      endcase
   endtask

   // idle burst on the sending side, valid drops for its length
   task automatic random_gap();
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // send one command word and hold it until taken
   task automatic send_command(input cpt_pkg::req_type c);
      random_gap();
      req_data <= c;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_command(c);
      words_sent++;
   endtask

   function automatic cpt_pkg::req_type make_command(input logic [2:0] op,
                                                     input logic [5:0] idx,
                                                     input logic [63:0] cost,
                                                     input logic [1:0] t,
                                                     input logic [6:0] lim);
      cpt_pkg::req_type c;
      c.operation = op;
      c.entry_index = idx;
      c.call_cost = cost;
      c.new_tier = t;
      c.rank_limit = lim;
      return c;
   endfunction

   function automatic logic [63:0] rand_cost();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return {32'hffff_ffff, $urandom()};
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      // an ignored command gives no result word to wait for
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input logic [cpt_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [31:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         cpt_pkg::CSR_PROMOTE_EN: cfg_shadow.promote_en = value[0];
         cpt_pkg::CSR_THRESH0: cfg_shadow.thresh0 = value;
         cpt_pkg::CSR_THRESH1: cfg_shadow.thresh1 = value;
         cpt_pkg::CSR_THRESH2: cfg_shadow.thresh2 = value;
         default: ;
      endcase
   endtask

   // receiver stall bursts
   always @(posedge clock) begin
      if (!idle_enable || reset) rsp_stall <= 1'b0;
      else if (rsp_stall) rsp_stall <= ($urandom_range(0, 8) != 0);
      else rsp_stall <= ($urandom_range(0, 5) == 0);
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin
      cpt_pkg::rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", 64'(rsp_data.status), 64'd0);
         end else begin
            w = expected_words.pop_front();
            if (rsp_data.status !== w.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(w.status));
            if (rsp_data.result_index !== w.result_index)
               report_mismatch("result_index", 64'(rsp_data.result_index),
                               64'(w.result_index));
            if (rsp_data.entry_calls !== w.entry_calls)
               report_mismatch("entry_calls", rsp_data.entry_calls, w.entry_calls);
            if (rsp_data.cycle_sum !== w.cycle_sum)
               report_mismatch("cycle_sum", rsp_data.cycle_sum, w.cycle_sum);
            if (rsp_data.cycle_min !== w.cycle_min)
               report_mismatch("cycle_min", rsp_data.cycle_min, w.cycle_min);
            if (rsp_data.cycle_max !== w.cycle_max)
               report_mismatch("cycle_max", rsp_data.cycle_max, w.cycle_max);
            if (rsp_data.tier !== w.tier)
               report_mismatch("tier", 64'(rsp_data.tier), 64'(w.tier));
            if (rsp_data.promote_flag !== w.promote_flag)
               report_mismatch("promote_flag", 64'(rsp_data.promote_flag),
                               64'(w.promote_flag));
            if (rsp_data.hot_flag !== w.hot_flag)
               report_mismatch("hot_flag", 64'(rsp_data.hot_flag), 64'(w.hot_flag));
            if (rsp_data.global_calls !== w.global_calls)
               report_mismatch("global_calls", rsp_data.global_calls, w.global_calls);
            if (rsp_data.last !== w.last)
               report_mismatch("last", 64'(rsp_data.last), 64'(w.last));
         end
         words_checked++;
      end
   end

   // directed: every operation, full table, bad indexes, wraps, empty rank
   task automatic test_directed();
      send_command(make_command(cpt_pkg::OP_RANK, 6'd0, '0, 2'd0, 7'd5));
      send_command(make_command(cpt_pkg::OP_QUERY, 6'd0, '0, 2'd0, 7'd0));
      send_command(make_command(cpt_pkg::OP_REGISTER, 6'd0, '0, 2'd0, 7'd0));
      send_command(make_command(cpt_pkg::OP_RECORD, 6'd0, '1, 2'd0, 7'd0));
      send_command(make_command(cpt_pkg::OP_RECORD, 6'd0, 64'd2, 2'd0, 7'd0));
      send_command(make_command(cpt_pkg::OP_RECORD, 6'd0, '0, 2'd0, 7'd0));
      send_command(make_command(cpt_pkg::OP_MARK, 6'd0, '0, 2'd3, 7'd0));
      send_command(make_command(cpt_pkg::OP_RECORD, 6'd63, '1, 2'd0, 7'd0));
      send_command(make_command(cpt_pkg::OP_MARK, 6'd1, '0, 2'd1, 7'd0));
      send_command(make_command(cpt_pkg::OP_REGISTER, 6'd0, '0, 2'd0, 7'd0));
      send_command(make_command(3'd6, 6'd0, '0, 2'd0, 7'd0));
      send_command(make_command(3'd7, 6'd63, '1, 2'd3, 7'd127));
      send_command(make_command(cpt_pkg::OP_RANK, 6'd0, '0, 2'd0, 7'd0));
      send_command(make_command(cpt_pkg::OP_RANK, 6'd0, '0, 2'd0, 7'd127));
      send_command(make_command(cpt_pkg::OP_QUERY, 6'd1, '0, 2'd0, 7'd0));
      for (int i = 0; i < ENTRIES - 1; i++)
         send_command(make_command(cpt_pkg::OP_REGISTER, 6'd0, '0, 2'd0, 7'd0));
      send_command(make_command(cpt_pkg::OP_RANK, 6'd0, '0, 2'd0, 7'd64));
      send_command(make_command(cpt_pkg::OP_CLEAR, 6'd0, '0, 2'd0, 7'd0));
   endtask

   // random traffic, with bad indexes and unknown operations, under one register setting
   task automatic test_random_phase(input int unsigned count);
      logic [2:0] op;
      logic [5:0] idx;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 19))
            0: op = cpt_pkg::OP_CLEAR;
            1, 2, 3: op = cpt_pkg::OP_REGISTER;
            4, 5, 6, 7, 8, 9, 10, 11: op = cpt_pkg::OP_RECORD;
            12, 13: op = cpt_pkg::OP_QUERY;
            14, 15: op = cpt_pkg::OP_MARK;
            16, 17: op = cpt_pkg::OP_RANK;
            default: op = (used_shadow == 0) ? cpt_pkg::OP_REGISTER :
                                               3'($urandom_range(0, 7));
         endcase
         if (used_shadow != 0 && $urandom_range(0, 9) != 0)
            idx = 6'($urandom_range(0, used_shadow - 1));
         else
            idx = 6'($urandom_range(0, 63));
         send_command(make_command(op, idx, rand_cost(), 2'($urandom_range(0, 3)),
                                   ($urandom_range(0, 3) == 0) ?
                                      7'($urandom_range(0, 127)) :
                                      7'($urandom_range(0, 6))));
      end
   endtask

   task automatic test_register_settings();
      write_register(cpt_pkg::CSR_PROMOTE_EN, 32'd1);
      write_register(cpt_pkg::CSR_THRESH0, 32'd2);
      write_register(cpt_pkg::CSR_THRESH1, 32'd0);
      write_register(cpt_pkg::CSR_THRESH2, 32'd4);
      test_random_phase(120);
      wait_drained();
      write_register(cpt_pkg::CSR_THRESH0, 32'hffff_ffff);
      write_register(cpt_pkg::CSR_THRESH1, 32'd3);
      write_register(cpt_pkg::CSR_THRESH2, 32'd0);
      test_random_phase(100);
      wait_drained();
      write_register(cpt_pkg::CSR_PROMOTE_EN, 32'd0);
      write_register(cpt_pkg::CSR_THRESH0, 32'd0);
      write_register(cpt_pkg::CSR_THRESH2, 32'hffff_ffff);
      test_random_phase(60);
      wait_drained();
      write_register(cpt_pkg::CSR_PROMOTE_EN, 32'd1);
      write_register(cpt_pkg::CSR_THRESH0, 32'd1);
      write_register(cpt_pkg::CSR_THRESH1, 32'd1);
      idle_enable = 1'b0;
      test_random_phase(90);
   endtask

   initial begin
      cfg_shadow = '{promote_en: 1'b0, thresh0: cpt_pkg::THRESH0_RESET,
                     thresh1: cpt_pkg::THRESH1_RESET,
                     thresh2: cpt_pkg::THRESH2_RESET};
      used_shadow = 0;
      total_shadow = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();
      test_register_settings();
      wait_drained();
      $display("sent %0d command words, checked %0d result words", words_sent,
               words_checked);
      $display("covered all operations, full table, bad indexes and four register sets");
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("simulation failed");
      $finish;
   end

endmodule

### files.f
rtl/cpt_pkg.sv
rtl/cpt_update.sv
rtl/call_profile_table_with_tier_trigger.sv
sim/call_profile_table_with_tier_trigger_tb.sv
